// File: rtl/caldate_pkg.sv
package caldate_pkg;

	// Widths fixed by the word formats
	localparam int CMD_W      = 3;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int DIFF_W     = 22;
	localparam int R100_W     = 7;
	localparam int MAX_YEAR_W = 16;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SET  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEXT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PREV = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIFF = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

	// Register indexes (word address bit)
	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	// Calendar constants
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
	localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;
	localparam logic [DAY_W-1:0]   FEB_DAYS  = 5'd28;
	localparam logic [DAY_W-1:0]   SHORT_DAYS = 5'd30;
	localparam logic [R100_W-1:0]  LAST_R100 = 7'd99;
	localparam int DAYS_PER_YEAR = 365;
	localparam int BASE_YEAR     = 1900;
	localparam int BASE_Q100     = 19;
	localparam int RESET_MAX_YEAR = 2100;
	localparam int RECIP_100     = 5243;
	localparam int RECIP_SHIFT   = 19;
	localparam int DIFF_HI = 2 ** (DIFF_W - 1) - 1;
	localparam int DIFF_LO = -(2 ** (DIFF_W - 1));

	typedef struct packed {
		logic [9:0]        q;
		logic [R100_W-1:0] r;
	} div100_t;

	// Quotient and remainder by 100: reciprocal estimate, one correction
	function automatic div100_t div100(input logic [MAX_YEAR_W-1:0] y);
		logic [MAX_YEAR_W+12:0] prod;
		logic [9:0]             q;
		logic [MAX_YEAR_W:0]    t;
		div100_t                qr;
		prod = (MAX_YEAR_W+13)'(y) * (MAX_YEAR_W+13)'(RECIP_100);
		q = prod[MAX_YEAR_W+12:RECIP_SHIFT];
		t = (MAX_YEAR_W+1)'(y) - ((MAX_YEAR_W+1)'(q) << 6)
			- ((MAX_YEAR_W+1)'(q) << 5) - ((MAX_YEAR_W+1)'(q) << 2);
		if (t[MAX_YEAR_W]) begin
			q = q - 10'd1;
			t = t + (MAX_YEAR_W+1)'(100);
		end
		qr.q = q;
		qr.r = t[R100_W-1:0];
		return qr;
	endfunction

	// Gregorian leap rule from the low year bits, year mod 100 and year/100
	function automatic logic is_leap(input logic [1:0] y_lo, input logic [R100_W-1:0] r100,
			input logic [1:0] q_lo);
		return ((y_lo == 2'd0) && (r100 != '0)) || ((r100 == '0) && (q_lo == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = SHORT_DAYS;
			MONTH_FEB:               n = leap ? FEB_LEAP_DAYS : FEB_DAYS;
			default:                 n = DAY_LAST;
		endcase
		return n;
	endfunction

	// Days in the year before the first of the month
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/caldate_ifs.sv
interface caldate_cmd_if import caldate_pkg::*; #(parameter int YEAR_BITS = 12);
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [MONTH_W-1:0]   month_in;
	logic [DAY_W-1:0]     day_in;
	logic [YEAR_BITS-1:0] year_in;

	modport source (output valid, command, month_in, day_in, year_in, input ready);
	modport sink (input valid, command, month_in, day_in, year_in, output ready);
endinterface

interface caldate_res_if import caldate_pkg::*; #(parameter int YEAR_BITS = 12);
	logic                 valid;
	logic                 ready;
	logic [MONTH_W-1:0]   month_out;
	logic [DAY_W-1:0]     day_out;
	logic [YEAR_BITS-1:0] year_out;
	logic                 leap_year;
	logic [DAY_W-1:0]     month_length;
	logic [DIFF_W-1:0]    day_difference;
	logic                 input_invalid;
	logic                 year_limit;

	modport source (output valid, month_out, day_out, year_out, leap_year, month_length,
		day_difference, input_invalid, year_limit, input ready);
	modport sink (input valid, month_out, day_out, year_out, leap_year, month_length,
		day_difference, input_invalid, year_limit, output ready);
endinterface

// File: rtl/calendar_date_counter.sv
// Channel   Dir  Handshake    Word
// cmd       in   valid/ready  command, month_in, day_in, year_in
// res       out  valid/ready  date, leap flag, month length, difference, flags
// apb       in   psel/penable min_year (0x0), max_year (0x4), pready tied high
//
// One word enters per cycle unless a stalled result backs up the full stages.
// Stages: input register, validation and divide by 100, date update, day count.
// The stored date moves once per cycle unless stalled, as each command enters stage 3, so commands follow back to back.
// Reset (arst_n low) loads 1/1/1900 and the year window 1900..2100 at once.
// A stalled result holds only the stages behind it that are full.
module calendar_date_counter import caldate_pkg::*; #(
	parameter int YEAR_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	caldate_cmd_if.sink       cmd,
	caldate_res_if.source     res
);

	localparam int Q_W  = YEAR_BITS - 6;
	localparam int DN_W = YEAR_BITS + 10;
	localparam logic [YEAR_BITS-1:0] YEAR_TOP = {YEAR_BITS{1'b1}};
	localparam logic signed [DN_W:0] SAT_HI = (DN_W+1)'(DIFF_HI);
	localparam logic signed [DN_W:0] SAT_LO = (DN_W+1)'(DIFF_LO);

	// Day count from the start of year 0 to the given date
	function automatic logic [DN_W-1:0] day_number(input logic [YEAR_BITS-1:0] y,
			input logic [Q_W-1:0] q, input logic [R100_W-1:0] r,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d, input logic leap);
		logic [DN_W-1:0] n;
		n = DN_W'(y) * DN_W'(DAYS_PER_YEAR);
		n = n + DN_W'(y[YEAR_BITS-1:2]) + DN_W'(y[1:0] != 2'd0);
		n = n - DN_W'(q) - DN_W'(r != '0);
		n = n + DN_W'(q[Q_W-1:2]) + DN_W'(!((r == '0) && (q[1:0] == 2'd0)));
		n = n + DN_W'(days_before(m)) + DN_W'((m > MONTH_FEB) && leap) + DN_W'(d);
		return n;
	endfunction

	// Configuration registers
	logic [YEAR_BITS-1:0] min_year_q, max_year_q;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_MAX_YEAR) ? DATA_W'(max_year_q) : DATA_W'(min_year_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= YEAR_BITS'(BASE_YEAR);
			max_year_q <= YEAR_BITS'(RESET_MAX_YEAR);
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[ADDR_W-1])
				REG_MIN_YEAR: min_year_q <= pwdata[YEAR_BITS-1:0];
				REG_MAX_YEAR: max_year_q <= pwdata[YEAR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage occupancy and advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	assign load_s4   = !v_s4 || res.ready;
	assign load_s3   = !v_s3 || load_s4;
	assign load_s2   = !v_s2 || load_s3;
	assign load_s1   = !v_s1 || load_s2;
	assign cmd.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (load_s1) v_s1 <= cmd.valid;
			if (load_s2) v_s2 <= v_s1;
			if (load_s3) v_s3 <= v_s2;
			if (load_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: input word
	logic [CMD_W-1:0]     cmd_s1;
	logic [MONTH_W-1:0]   month_s1;
	logic [DAY_W-1:0]     day_s1;
	logic [YEAR_BITS-1:0] year_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd.command;
			month_s1 <= cmd.month_in;
			day_s1   <= cmd.day_in;
			year_s1  <= cmd.year_in;
		end
	end

	// Validate the input date; replace a bad one with 1/1/1900
	div100_t        in_qr;
	logic [Q_W-1:0] in_q;
	logic           in_leap, in_ok;

	assign in_qr   = div100(MAX_YEAR_W'(year_s1));
	assign in_q    = in_qr.q[Q_W-1:0];
	assign in_leap = is_leap(year_s1[1:0], in_qr.r, in_q[1:0]);
	assign in_ok   = (year_s1 >= min_year_q) && (year_s1 <= max_year_q)
		&& (month_s1 >= MONTH_JAN) && (month_s1 <= MONTH_DEC)
		&& (day_s1 >= DAY_FIRST) && (day_s1 <= month_days(month_s1, in_leap));

	logic [CMD_W-1:0]     cmd_s2;
	logic [MONTH_W-1:0]   month_s2;
	logic [DAY_W-1:0]     day_s2;
	logic [YEAR_BITS-1:0] year_s2;
	logic [Q_W-1:0]       q100_s2;
	logic [R100_W-1:0]    r100_s2;
	logic                 leap_s2, invalid_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			cmd_s2     <= cmd_s1;
			invalid_s2 <= !in_ok;
			if (in_ok) begin
				month_s2 <= month_s1;
				day_s2   <= day_s1;
				year_s2  <= year_s1;
				q100_s2  <= in_q;
				r100_s2  <= in_qr.r;
				leap_s2  <= in_leap;
			end else begin
				month_s2 <= MONTH_JAN;
				day_s2   <= DAY_FIRST;
				year_s2  <= YEAR_BITS'(BASE_YEAR);
				q100_s2  <= Q_W'(BASE_Q100);
				r100_s2  <= '0;
				leap_s2  <= 1'b0;
			end
		end
	end

	// Stored date, with the year also held as year/100 and year mod 100
	logic [MONTH_W-1:0]   cur_month_q;
	logic [DAY_W-1:0]     cur_day_q;
	logic [YEAR_BITS-1:0] cur_year_q;
	logic [Q_W-1:0]       cur_q100_q;
	logic [R100_W-1:0]    cur_r100_q;

	logic                 cur_leap;
	logic [DAY_W-1:0]     cur_len;
	logic [MONTH_W-1:0]   nxt_month;
	logic [DAY_W-1:0]     nxt_day;
	logic [YEAR_BITS-1:0] nxt_year;
	logic [Q_W-1:0]       nxt_q100;
	logic [R100_W-1:0]    nxt_r100;
	logic                 nxt_limit;

	assign cur_leap = is_leap(cur_year_q[1:0], cur_r100_q, cur_q100_q[1:0]);
	assign cur_len  = month_days(cur_month_q, cur_leap);

	// Work out the date after the command
	always_comb begin
		nxt_month = cur_month_q;
		nxt_day   = cur_day_q;
		nxt_year  = cur_year_q;
		nxt_q100  = cur_q100_q;
		nxt_r100  = cur_r100_q;
		nxt_limit = 1'b0;
		case (cmd_s2)
			CMD_SET: begin
				nxt_month = month_s2;
				nxt_day   = day_s2;
				nxt_year  = year_s2;
				nxt_q100  = q100_s2;
				nxt_r100  = r100_s2;
			end
			CMD_NEXT: begin
				if (cur_day_q < cur_len) begin
					nxt_day = cur_day_q + DAY_W'(1);
				end else if (cur_month_q < MONTH_DEC) begin
					nxt_day   = DAY_FIRST;
					nxt_month = cur_month_q + MONTH_W'(1);
				end else if (cur_year_q < YEAR_TOP) begin
					nxt_day   = DAY_FIRST;
					nxt_month = MONTH_JAN;
					nxt_year  = cur_year_q + YEAR_BITS'(1);
					if (cur_r100_q == LAST_R100) begin
						nxt_r100 = '0;
						nxt_q100 = cur_q100_q + Q_W'(1);
					end else begin
						nxt_r100 = cur_r100_q + R100_W'(1);
					end
				end else begin
					nxt_limit = 1'b1;
				end
			end
			CMD_PREV: begin
				if (cur_day_q > DAY_FIRST) begin
					nxt_day = cur_day_q - DAY_W'(1);
				end else if (cur_month_q > MONTH_JAN) begin
					nxt_month = cur_month_q - MONTH_W'(1);
					nxt_day   = month_days(cur_month_q - MONTH_W'(1), cur_leap);
				end else if (cur_year_q != '0) begin
					nxt_month = MONTH_DEC;
					nxt_day   = DAY_LAST;
					nxt_year  = cur_year_q - YEAR_BITS'(1);
					if (cur_r100_q == '0) begin
						nxt_r100 = LAST_R100;
						nxt_q100 = cur_q100_q - Q_W'(1);
					end else begin
						nxt_r100 = cur_r100_q - R100_W'(1);
					end
				end else begin
					nxt_limit = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_month_q <= MONTH_JAN;
			cur_day_q   <= DAY_FIRST;
			cur_year_q  <= YEAR_BITS'(BASE_YEAR);
			cur_q100_q  <= Q_W'(BASE_Q100);
			cur_r100_q  <= '0;
		end else if (load_s3 && v_s2) begin
			cur_month_q <= nxt_month;
			cur_day_q   <= nxt_day;
			cur_year_q  <= nxt_year;
			cur_q100_q  <= nxt_q100;
			cur_r100_q  <= nxt_r100;
		end
	end

	// Stage 3: snapshot of the date after the step, input day count
	logic                 diff_s3, invalid_s3, limit_s3, leap_s3;
	logic [MONTH_W-1:0]   month_s3;
	logic [DAY_W-1:0]     day_s3;
	logic [YEAR_BITS-1:0] year_s3;
	logic [Q_W-1:0]       q100_s3;
	logic [R100_W-1:0]    r100_s3;
	logic [DN_W-1:0]      in_dn_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			diff_s3    <= (cmd_s2 == CMD_DIFF);
			invalid_s3 <= invalid_s2 && ((cmd_s2 == CMD_SET) || (cmd_s2 == CMD_DIFF));
			limit_s3   <= nxt_limit;
			month_s3   <= nxt_month;
			day_s3     <= nxt_day;
			year_s3    <= nxt_year;
			q100_s3    <= nxt_q100;
			r100_s3    <= nxt_r100;
			leap_s3    <= is_leap(nxt_year[1:0], nxt_r100, nxt_q100[1:0]);
			in_dn_s3   <= day_number(year_s2, q100_s2, r100_s2, month_s2, day_s2, leap_s2);
		end
	end

	// Stored day count minus input day count, saturated
	logic [DN_W-1:0]        cur_dn;
	logic signed [DN_W:0]   diff_full, diff_sat;

	assign cur_dn    = day_number(year_s3, q100_s3, r100_s3, month_s3, day_s3, leap_s3);
	assign diff_full = $signed({1'b0, cur_dn}) - $signed({1'b0, in_dn_s3});

	always_comb begin
		if (diff_full > SAT_HI)
			diff_sat = SAT_HI;
		else if (diff_full < SAT_LO)
			diff_sat = SAT_LO;
		else
			diff_sat = diff_full;
	end

	// Stage 4: result register
	logic [MONTH_W-1:0]   month_s4;
	logic [DAY_W-1:0]     day_s4, mlen_s4;
	logic [YEAR_BITS-1:0] year_s4;
	logic                 leap_s4, invalid_s4, limit_s4;
	logic [DIFF_W-1:0]    diff_s4;

	always_ff @(posedge clk) begin
		if (load_s4) begin
			month_s4   <= month_s3;
			day_s4     <= day_s3;
			year_s4    <= year_s3;
			leap_s4    <= leap_s3;
			mlen_s4    <= month_days(month_s3, leap_s3);
			diff_s4    <= diff_s3 ? diff_sat[DIFF_W-1:0] : '0;
			invalid_s4 <= invalid_s3;
			limit_s4   <= limit_s3;
		end
	end

	assign res.valid          = v_s4;
	assign res.month_out      = month_s4;
	assign res.day_out        = day_s4;
	assign res.year_out       = year_s4;
	assign res.leap_year      = leap_s4;
	assign res.month_length   = mlen_s4;
	assign res.day_difference = diff_s4;
	assign res.input_invalid  = invalid_s4;
	assign res.year_limit     = limit_s4;

endmodule

// File: rtl/caldate_checker.sv
module caldate_checker import caldate_pkg::*; #(
	parameter int YEAR_BITS = 12
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [MONTH_W-1:0]   month_out,
	input logic [DAY_W-1:0]     day_out,
	input logic [YEAR_BITS-1:0] year_out,
	input logic                 leap_year,
	input logic [DAY_W-1:0]     month_length,
	input logic [DIFF_W-1:0]    day_difference,
	input logic                 input_invalid,
	input logic                 year_limit
);

	// Hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({month_out, day_out, year_out,
			leap_year, month_length, day_difference, input_invalid, year_limit}))
		else $error("result word changed while stalled");

	// Stored date always lies within its month
	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (month_out >= MONTH_JAN) && (month_out <= MONTH_DEC)
			&& (day_out >= DAY_FIRST) && (day_out <= month_length))
		else $error("stored date out of range");

	// A 29-day month is February of a leap year
	a_feb: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (month_length == FEB_LEAP_DAYS) |-> leap_year && (month_out == MONTH_FEB))
		else $error("month length disagrees with leap flag");

	// Year limit comes only from a day step, never with the other flags
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && year_limit |-> !input_invalid && (day_difference == '0))
		else $error("year limit raised with set or difference flags");

endmodule

bind calendar_date_counter caldate_checker #(.YEAR_BITS(YEAR_BITS)) u_caldate_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.month_out      (res.month_out),
	.day_out        (res.day_out),
	.year_out       (res.year_out),
	.leap_year      (res.leap_year),
	.month_length   (res.month_length),
	.day_difference (res.day_difference),
	.input_invalid  (res.input_invalid),
	.year_limit     (res.year_limit)
);

// File: bench/calendar_date_counter_test.sv
module calendar_date_counter_test;
	import caldate_pkg::*;

	localparam int YEAR_BITS = 12;
	localparam int YEAR_TOP = 2 ** YEAR_BITS - 1;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 218;
	localparam int SETTLE_CYCLES = 8;
	// Codes outside the defined set, read back as a plain read
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic [YEAR_BITS-1:0] year;
		logic                 leap;
		logic [DAY_W-1:0]     length;
		logic [DIFF_W-1:0]    diff;
		logic                 invalid;
		logic                 limit;
	} date_word_t;

	// Running copy of the stored date and year window, with the words it predicts
	class calendar_tracker;
		logic [YEAR_BITS-1:0] min_yr;
		logic [YEAR_BITS-1:0] max_yr;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic [YEAR_BITS-1:0] year;
		date_word_t           expected_words[$];
		int                   mismatches;

		function new();
			min_yr = YEAR_BITS'(BASE_YEAR);
			max_yr = YEAR_BITS'(RESET_MAX_YEAR);
			month = MONTH_JAN;
			day = DAY_FIRST;
			year = YEAR_BITS'(BASE_YEAR);
			mismatches = 0;
		endfunction

		function bit leap_of(logic [YEAR_BITS-1:0] y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function logic [DAY_W-1:0] days_in(logic [MONTH_W-1:0] m, logic [YEAR_BITS-1:0] y);
			case (m)
				MONTH_FEB:          return leap_of(y) ? FEB_LEAP_DAYS : FEB_DAYS;
				4'd4, 4'd6, 4'd9, 4'd11: return SHORT_DAYS;
				default:            return DAY_LAST;
			endcase
		endfunction

		function bit date_ok(logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
				logic [YEAR_BITS-1:0] y);
			if (y < min_yr || y > max_yr)
				return 0;
			if (m < MONTH_JAN || m > MONTH_DEC)
				return 0;
			if (d < DAY_FIRST || d > days_in(m, y))
				return 0;
			return 1;
		endfunction

		// Days from the start of year 0 up to a valid date
		function int day_count(logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
				logic [YEAR_BITS-1:0] y);
			int yy;
			int n;
			yy = int'(y);
			n = yy * DAYS_PER_YEAR + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400
				+ int'(d);
			case (m)
				4'd2:    n += 31;
				4'd3:    n += 59;
				4'd4:    n += 90;
				4'd5:    n += 120;
				4'd6:    n += 151;
				4'd7:    n += 181;
				4'd8:    n += 212;
				4'd9:    n += 243;
				4'd10:   n += 273;
				4'd11:   n += 304;
				4'd12:   n += 334;
				default: ;
			endcase
			if (m > MONTH_FEB && leap_of(y))
				n += 1;
			return n;
		endfunction

		function void set_window(logic idx, logic [YEAR_BITS-1:0] value);
			if (idx == REG_MIN_YEAR)
				min_yr = value;
			else
				max_yr = value;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		// Apply one accepted command word and queue the word it should produce
		function void note_command(logic [CMD_W-1:0] c, logic [MONTH_W-1:0] m,
				logic [DAY_W-1:0] d, logic [YEAR_BITS-1:0] y);
			date_word_t w;
			int span;
			w = '0;
			case (c)
				CMD_SET: begin
					if (date_ok(m, d, y)) begin
						month = m;
						day = d;
						year = y;
					end else begin
						month = MONTH_JAN;
						day = DAY_FIRST;
						year = YEAR_BITS'(BASE_YEAR);
						w.invalid = 1'b1;
					end
				end
				CMD_NEXT: begin
					if (day < days_in(month, year))
						day = day + DAY_W'(1);
					else if (month < MONTH_DEC) begin
						day = DAY_FIRST;
						month = month + MONTH_W'(1);
					end else if (year < YEAR_TOP) begin
						day = DAY_FIRST;
						month = MONTH_JAN;
						year = year + YEAR_BITS'(1);
					end else
						w.limit = 1'b1;
				end
				CMD_PREV: begin
					if (day > DAY_FIRST)
						day = day - DAY_W'(1);
					else if (month > MONTH_JAN) begin
						month = month - MONTH_W'(1);
						day = days_in(month, year);
					end else if (year > 0) begin
						year = year - YEAR_BITS'(1);
						month = MONTH_DEC;
						day = DAY_LAST;
					end else
						w.limit = 1'b1;
				end
				CMD_DIFF: begin
					if (!date_ok(m, d, y)) begin
						m = MONTH_JAN;
						d = DAY_FIRST;
						y = YEAR_BITS'(BASE_YEAR);
						w.invalid = 1'b1;
					end
					span = day_count(month, day, year) - day_count(m, d, y);
					if (span > DIFF_HI)
						span = DIFF_HI;
					if (span < DIFF_LO)
						span = DIFF_LO;
					w.diff = DIFF_W'(span);
				end
				default: ;
			endcase
			w.month = month;
			w.day = day;
			w.year = year;
			w.leap = leap_of(year);
			w.length = days_in(month, year);
			expected_words.push_back(w);
		endfunction

		// Compare one delivered word with the oldest prediction
		function void check_result(date_word_t got);
			date_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h with nothing outstanding", got);
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch want m=%0d d=%0d y=%0d leap=%0d len=%0d diff=%0d inv=%0d lim=%0d",
						want.month, want.day, want.year, want.leap, want.length,
						$signed(want.diff), want.invalid, want.limit);
					$display("         got  m=%0d d=%0d y=%0d leap=%0d len=%0d diff=%0d inv=%0d lim=%0d",
						got.month, got.day, got.year, got.leap, got.length,
						$signed(got.diff), got.invalid, got.limit);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	caldate_cmd_if #(.YEAR_BITS(YEAR_BITS)) cmd_ch();
	caldate_res_if #(.YEAR_BITS(YEAR_BITS)) res_ch();

	calendar_date_counter #(.YEAR_BITS(YEAR_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	calendar_tracker tracker;
	bit calm = 0;
	int items_sent = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int cycle_count = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Give up on a hung run
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Receiver: random stalls, and a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			res_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_taken <= hold_taken + 1;
		end else
			res_ch.ready <= calm || ($urandom_range(99) >= 11);
	end

	// Note each accepted command word, then check each delivered result word
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				tracker.note_command(cmd_ch.command, cmd_ch.month_in, cmd_ch.day_in,
					cmd_ch.year_in);
			if (res_ch.valid && res_ch.ready)
				tracker.check_result('{res_ch.month_out, res_ch.day_out, res_ch.year_out,
					res_ch.leap_year, res_ch.month_length, res_ch.day_difference,
					res_ch.input_invalid, res_ch.year_limit});
		end
	end

	// Offer one command word and hold it until taken
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d, input logic [YEAR_BITS-1:0] y);
		if (!calm && $urandom_range(99) < 11) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.month_in <= m;
		cmd_ch.day_in <= d;
		cmd_ch.year_in <= y;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent++;
	endtask

	// Offer a word with random fields and the given command
	task automatic send_noise(input logic [CMD_W-1:0] c);
		send_word(c, MONTH_W'($urandom_range(15)), DAY_W'($urandom_range(31)),
			YEAR_BITS'($urandom_range(YEAR_TOP)));
	endtask

	// Hold the sender until every predicted word is back, then let the pipe settle
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle
	task automatic write_reg(input logic idx, input logic [YEAR_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_window(idx, value);
	endtask

	task automatic set_window(input logic [YEAR_BITS-1:0] lo, input logic [YEAR_BITS-1:0] hi);
		drain();
		write_reg(REG_MIN_YEAR, lo);
		write_reg(REG_MAX_YEAR, hi);
	endtask

	// Pick a date inside the window (any fields when the window is empty), leaning on its edges and on month ends
	task automatic pick_date(output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d,
			output logic [YEAR_BITS-1:0] y);
		logic [DAY_W-1:0] len;
		if (tracker.min_yr > tracker.max_yr) begin
			m = MONTH_W'($urandom_range(15));
			d = DAY_W'($urandom_range(31));
			y = YEAR_BITS'($urandom_range(YEAR_TOP));
			return;
		end
		case ($urandom_range(3))
			0:       y = tracker.min_yr;
			1:       y = tracker.max_yr;
			default: y = YEAR_BITS'($urandom_range(tracker.max_yr, tracker.min_yr));
		endcase
		case ($urandom_range(7))
			0:       m = MONTH_DEC;
			1:       m = MONTH_JAN;
			default: m = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
		endcase
		len = tracker.days_in(m, y);
		case ($urandom_range(3))
			0:       d = len;
			1:       d = DAY_FIRST;
			default: d = DAY_W'($urandom_range(len, DAY_FIRST));
		endcase
	endtask

	// Break one field of a well-formed date
	task automatic spoil_date(inout logic [MONTH_W-1:0] m, inout logic [DAY_W-1:0] d,
			inout logic [YEAR_BITS-1:0] y);
		logic [DAY_W-1:0] len;
		len = tracker.days_in(m, y);
		case ($urandom_range(2))
			0: d = (len == DAY_LAST) ? 5'd0 : DAY_W'($urandom_range(DAY_LAST, len + DAY_W'(1)));
			1: m = $urandom_range(1) ? 4'd0 : MONTH_W'($urandom_range(15, 13));
			default: begin
				if (tracker.min_yr > 0)
					y = tracker.min_yr - YEAR_BITS'(1);
				else if (tracker.max_yr < YEAR_TOP)
					y = tracker.max_yr + YEAR_BITS'(1);
				else
					m = 4'd0;
			end
		endcase
	endtask

	// One burst: a set (or noise), then a run of steps mostly in one direction, mixed with differences and reads
	task automatic random_burst();
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		logic [YEAR_BITS-1:0] y;
		logic [CMD_W-1:0]   dir;
		int pick;
		int run;
		pick = $urandom_range(99);
		if (pick < 15)
			send_noise(CMD_W'($urandom_range(7)));
		else begin
			pick_date(m, d, y);
			if (pick < 25)
				spoil_date(m, d, y);
			send_word(CMD_SET, m, d, y);
		end
		dir = $urandom_range(1) ? CMD_NEXT : CMD_PREV;
		run = $urandom_range(8, 1);
		repeat (run) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_noise(dir);
			else if (pick < 85) begin
				pick_date(m, d, y);
				if (pick < 73)
					spoil_date(m, d, y);
				send_word(CMD_DIFF, m, d, y);
			end else if (pick < 92)
				send_noise(CMD_READ);
			else
				send_noise((dir == CMD_NEXT) ? CMD_PREV : CMD_NEXT);
		end
	endtask

	initial begin
		int lo;
		int hi;
		int phase_end;
		bit paused;
		paused = 1'b0;
		tracker = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_READ;
		cmd_ch.month_in = '0;
		cmd_ch.day_in = '0;
		cmd_ch.year_in = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window: leap days, roll-over past max_year, each way a date fails
		send_word(CMD_READ, 4'd0, 5'd0, 12'd0);
		send_word(CMD_SET, MONTH_FEB, 5'd29, 12'd2000);
		send_word(CMD_NEXT, 4'd15, 5'd31, 12'd4095);
		send_word(CMD_PREV, 4'd0, 5'd0, 12'd0);
		send_word(CMD_SET, MONTH_FEB, 5'd29, 12'd1900);
		send_word(CMD_SET, MONTH_DEC, DAY_LAST, 12'd2100);
		send_word(CMD_NEXT, 4'd0, 5'd0, 12'd0);
		send_word(CMD_PREV, 4'd0, 5'd0, 12'd0);
		send_word(CMD_SET, 4'd4, DAY_LAST, 12'd2000);
		send_word(CMD_SET, 4'd0, 5'd10, 12'd2000);
		send_word(CMD_SET, 4'd15, DAY_LAST, 12'd4095);
		send_word(CMD_SET, MONTH_JAN, 5'd0, 12'd1950);
		send_word(CMD_SET, 4'd7, 5'd15, 12'd1899);
		send_word(CMD_SET, 4'd3, DAY_FIRST, 12'd2000);
		send_word(CMD_DIFF, MONTH_JAN, DAY_FIRST, 12'd1900);
		send_word(CMD_DIFF, 4'd13, DAY_FIRST, 12'd2000);
		send_word(CMD_SPARE_LO, 4'd5, 5'd5, 12'd2005);
		send_word(CMD_SPARE_HI, 4'd15, 5'd31, 12'd4095);

		// Full window: both year bounds of the counter
		set_window(12'd0, 12'd4095);
		send_word(CMD_SET, MONTH_DEC, DAY_LAST, 12'd4095);
		send_word(CMD_NEXT, 4'd0, 5'd0, 12'd0);
		send_word(CMD_DIFF, MONTH_JAN, DAY_FIRST, 12'd0);
		send_word(CMD_SET, MONTH_JAN, DAY_FIRST, 12'd0);
		send_word(CMD_PREV, 4'd0, 5'd0, 12'd0);
		send_word(CMD_DIFF, MONTH_DEC, DAY_LAST, 12'd4095);

		// Empty window: every date fails
		set_window(12'd3000, 12'd100);
		send_word(CMD_SET, 4'd6, 5'd15, 12'd2000);
		send_word(CMD_DIFF, 4'd6, 5'd15, 12'd2000);

		// Random phases, one window each
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin lo = BASE_YEAR; hi = RESET_MAX_YEAR; end
				1: begin lo = 0; hi = YEAR_TOP; end
				2: begin
					lo = $urandom_range(YEAR_TOP);
					hi = $urandom_range(YEAR_TOP, lo);
				end
				3: begin lo = 2000; hi = 2000; end
				4: begin lo = 2500; hi = 1200; end
				5: begin lo = 0; hi = 0; end
				default: begin lo = YEAR_TOP; hi = YEAR_TOP; end
			endcase
			set_window(YEAR_BITS'(lo), YEAR_BITS'(hi));
			calm = (p == 1);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				// Stall the receiver while the sender keeps pushing
				if (p == 1 && hold_asked == 0 && items_sent > phase_end - PHASE_ITEMS + 30)
					hold_asked = 1;
				// Pause mid-phase until the pipe is empty
				if (p == 2 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
					paused = 1'b1;
					drain();
				end
				random_burst();
			end
		end
		calm = 0;

		drain();
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
